[rtl/nrtm_pkg.sv]
// Shared types, codes and field widths for the neighbour rule tile matcher.
`default_nettype none

package nrtm_pkg;

    // Fixed field widths of the item and configuration interfaces.
    localparam int COORD_W      = 6;
    localparam int RIDX_FIELD_W = 4;
    localparam int COND_W       = 16;
    localparam int TEX_FIELD_W  = 16;
    localparam int TILE_FIELD_W = 8;
    localparam int DIM_FIELD_W  = 7;
    localparam int RCNT_FIELD_W = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int S_TDATA_W    = 56;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 16;

    // Defaults for the top-level parameters.
    localparam int MAX_RULES_DEF    = 16;
    localparam int MAP_SIDE_DEF     = 64;
    localparam int TILE_BITS_DEF    = 8;
    localparam int TEXTURE_BITS_DEF = 16;

    // Reset values of the configuration registers.
    localparam logic [DIM_FIELD_W-1:0] MAP_DIM_RESET = DIM_FIELD_W'(64);

    localparam int NB_COUNT = 8;
    localparam int NB_IDX_W = 3;
    localparam int NB_CNT_W = 4;

    typedef enum logic [1:0] {
        ACT_WRITE_RULE = 2'd0,
        ACT_WRITE_CELL = 2'd1,
        ACT_QUERY      = 2'd2,
        ACT_NONE       = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH        = 3'd0,
        REG_MAP_HEIGHT       = 3'd1,
        REG_MATCH_TILE       = 3'd2,
        REG_RULE_COUNT       = 3'd3,
        REG_FALLBACK_TEXTURE = 3'd4
    } cfg_reg_t;

    // Two-bit neighbour condition codes; the fourth code also means skip.
    localparam logic [1:0] COND_SKIP     = 2'd0;
    localparam logic [1:0] COND_INCLUDED = 2'd1;
    localparam logic [1:0] COND_EXCLUDED = 2'd2;

    typedef enum logic [1:0] {
        OFS_NEG  = 2'd0,
        OFS_ZERO = 2'd1,
        OFS_POS  = 2'd2
    } ofs_t;

    // Neighbour visiting order: top row left to right, middle row, bottom row.
    localparam ofs_t NB_DX [NB_COUNT] = '{OFS_NEG, OFS_ZERO, OFS_POS, OFS_NEG,
                                          OFS_POS, OFS_NEG, OFS_ZERO, OFS_POS};
    localparam ofs_t NB_DY [NB_COUNT] = '{OFS_POS, OFS_POS, OFS_POS, OFS_ZERO,
                                          OFS_ZERO, OFS_NEG, OFS_NEG, OFS_NEG};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NEIGHBOURS,
        ST_RULES,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/neighbour_rule_tile_matcher_core.sv]
// Top level: 3x3 neighbour rule tile matcher with map and rule memories.
//
// Input items arrive on s_tvalid/s_tready with the action in s_tuser. A write
// rule or write cell item is taken and gives no result. A query item reads
// its eight neighbours from the map memory, one read per cycle, then reads the
// rule memory one rule per cycle and tests each rule as its data returns,
// stopping at the first match. The next item is accepted when the result has
// been moved to the output register, so no new item is taken while a query is
// in progress. The single read port of each memory sets the pace of the scans.
// Results leave on m_tvalid/m_tready, texture in m_tdata and the fallback flag
// in m_tuser. A result held by a stalled receiver does not block the block: a
// finished query waits only if the previous result is still in the output
// register. Configuration writes through cfg_wr_en take effect at once; the
// user must make them only while no query is in progress, as the block itself
// does not enforce this. Reset clears the control state and sets the
// configuration registers to their reset values; memories hold nothing until
// written.
`default_nettype none

module neighbour_rule_tile_matcher_core
    import nrtm_pkg::*;
#(
    parameter int MAX_RULES    = MAX_RULES_DEF,
    parameter int MAP_SIDE     = MAP_SIDE_DEF,
    parameter int TILE_BITS    = TILE_BITS_DEF,
    parameter int TEXTURE_BITS = TEXTURE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input items.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata from bit 0: x[5:0], y[11:6], rule_index[15:12], conditions[31:16],
    // rule_texture[47:32], tile_value[55:48].
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: action[1:0].
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    // Result items.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata: texture[15:0].
    output logic [M_TDATA_W-1:0]       m_tdata,
    // m_tuser: used_fallback[0].
    output logic                       m_tuser,
    // Configuration writes.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DIM_W   = $clog2(MAP_SIDE + 1);
    localparam int ADDR_W  = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int RIDX_W  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int RCNT_W  = $clog2(MAX_RULES + 1);
    localparam int RULE_W  = COND_W + TEXTURE_BITS;

    // Input field split.
    logic [COORD_W-1:0]      in_x;
    logic [COORD_W-1:0]      in_y;
    logic [RIDX_FIELD_W-1:0] in_rule_index;
    logic [COND_W-1:0]       in_conditions;
    logic [TEX_FIELD_W-1:0]  in_rule_texture;
    logic [TILE_FIELD_W-1:0] in_tile_value;
    action_t                 in_action;

    assign in_x            = s_tdata[5:0];
    assign in_y            = s_tdata[11:6];
    assign in_rule_index   = s_tdata[15:12];
    assign in_conditions   = s_tdata[31:16];
    assign in_rule_texture = s_tdata[47:32];
    assign in_tile_value   = s_tdata[55:48];
    assign in_action       = action_t'(s_tuser);

    // Configuration registers.
    logic [DIM_FIELD_W-1:0]  map_width_reg;
    logic [DIM_FIELD_W-1:0]  map_height_reg;
    logic [TILE_FIELD_W-1:0] match_tile_reg;
    logic [RCNT_FIELD_W-1:0] rule_count_reg;
    logic [TEX_FIELD_W-1:0]  fallback_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= MAP_DIM_RESET;
            map_height_reg <= MAP_DIM_RESET;
            match_tile_reg <= '0;
            rule_count_reg <= '0;
            fallback_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_MAP_WIDTH:        map_width_reg  <= cfg_wdata[DIM_FIELD_W-1:0];
                REG_MAP_HEIGHT:       map_height_reg <= cfg_wdata[DIM_FIELD_W-1:0];
                REG_MATCH_TILE:       match_tile_reg <= cfg_wdata[TILE_FIELD_W-1:0];
                REG_RULE_COUNT:       rule_count_reg <= cfg_wdata[RCNT_FIELD_W-1:0];
                REG_FALLBACK_TEXTURE: fallback_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0]  width_eff;
    logic [DIM_W-1:0]  height_eff;
    logic [RCNT_W-1:0] rules_eff;

    assign width_eff  = (32'(map_width_reg) > MAP_SIDE) ? DIM_W'(MAP_SIDE)
                                                         : DIM_W'(map_width_reg);
    assign height_eff = (32'(map_height_reg) > MAP_SIDE) ? DIM_W'(MAP_SIDE)
                                                          : DIM_W'(map_height_reg);
    assign rules_eff  = (32'(rule_count_reg) > MAX_RULES) ? RCNT_W'(MAX_RULES)
                                                           : RCNT_W'(rule_count_reg);

    // Sequencer state.
    state_t                state_reg, state_next;
    logic [NB_CNT_W-1:0]   nb_cnt_reg, nb_cnt_next;
    logic [RCNT_W-1:0]     rule_ptr_reg, rule_ptr_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    // Payload registers.
    logic [COORD_W-1:0]     qx_reg, qy_reg;
    logic                   onmap_q_reg;
    logic [NB_COUNT-1:0]    eq_reg, eq_next;
    logic [M_TDATA_W-1:0]   res_tex_reg, res_tex_next;
    logic                   res_fb_reg, res_fb_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic                   m_tuser_reg;

    logic                   in_accept;
    logic                   load_out;

    // Neighbour address unit, shared by cell writes and query reads.
    logic [COORD_W-1:0]     ag_x, ag_y;
    ofs_t                   ag_dx, ag_dy;
    logic                   ag_on_map;
    logic [ADDR_W-1:0]      ag_addr;
    logic [NB_IDX_W-1:0]    nb_idx;

    assign nb_idx = nb_cnt_reg[NB_IDX_W-1:0];

    always_comb begin
        if (state_reg == ST_IDLE) begin
            ag_x  = in_x;
            ag_y  = in_y;
            ag_dx = OFS_ZERO;
            ag_dy = OFS_ZERO;
        end else begin
            ag_x  = qx_reg;
            ag_y  = qy_reg;
            ag_dx = NB_DX[nb_idx];
            ag_dy = NB_DY[nb_idx];
        end
    end

    nrtm_nb_addr #(
        .MAP_SIDE (MAP_SIDE)
    ) u_nb_addr (
        .x          (ag_x),
        .y          (ag_y),
        .dx         (ag_dx),
        .dy         (ag_dy),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .on_map     (ag_on_map),
        .addr       (ag_addr)
    );

    // Map memory.
    logic                 tile_we;
    logic                 tile_re;
    logic [TILE_BITS-1:0] tile_rd_data;

    assign tile_we = in_accept && (in_action == ACT_WRITE_CELL) && ag_on_map;
    assign tile_re = (state_reg == ST_NEIGHBOURS) && (nb_cnt_reg < NB_CNT_W'(NB_COUNT));

    nrtm_ram #(
        .WIDTH (TILE_BITS),
        .DEPTH (MAP_SIDE * MAP_SIDE)
    ) u_tile_ram (
        .aclk    (aclk),
        .wr_en   (tile_we),
        .wr_addr (ag_addr),
        .wr_data (TILE_BITS'(in_tile_value)),
        .rd_en   (tile_re),
        .rd_addr (ag_addr),
        .rd_data (tile_rd_data)
    );

    // Rule memory: conditions in the low bits, texture above.
    logic               rule_we;
    logic               rule_re;
    logic [RULE_W-1:0]  rule_rd_data;
    logic [COND_W-1:0]  rule_cond;
    logic               rule_ok;

    assign rule_we = in_accept && (in_action == ACT_WRITE_RULE)
                     && (32'(in_rule_index) < MAX_RULES);
    assign rule_re = (state_reg == ST_RULES) && (rule_ptr_reg < rules_eff);

    nrtm_ram #(
        .WIDTH (RULE_W),
        .DEPTH (MAX_RULES)
    ) u_rule_ram (
        .aclk    (aclk),
        .wr_en   (rule_we),
        .wr_addr (RIDX_W'(in_rule_index)),
        .wr_data ({TEXTURE_BITS'(in_rule_texture), in_conditions}),
        .rd_en   (rule_re),
        .rd_addr (RIDX_W'(rule_ptr_reg)),
        .rd_data (rule_rd_data)
    );

    assign rule_cond = rule_rd_data[COND_W-1:0];

    // An off-map neighbour has its equal bit clear, so it fails "included"
    // and passes "excluded".
    always_comb begin
        rule_ok = 1'b1;
        for (int k = 0; k < NB_COUNT; k++) begin
            if ((rule_cond[2*k +: 2] == COND_INCLUDED) && !eq_reg[k]) begin
                rule_ok = 1'b0;
            end
            if ((rule_cond[2*k +: 2] == COND_EXCLUDED) && eq_reg[k]) begin
                rule_ok = 1'b0;
            end
        end
    end

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign load_out  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        nb_cnt_next   = nb_cnt_reg;
        rule_ptr_next = rule_ptr_reg;
        eq_next       = eq_reg;
        res_tex_next  = res_tex_reg;
        res_fb_next   = res_fb_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept && (in_action == ACT_QUERY)) begin
                    nb_cnt_next = '0;
                    state_next  = ST_NEIGHBOURS;
                end
            end
            ST_NEIGHBOURS: begin
                // Data of the read issued in the previous cycle returns now.
                if (nb_cnt_reg != '0) begin
                    eq_next[NB_IDX_W'(nb_cnt_reg - NB_CNT_W'(1))] =
                        onmap_q_reg && (tile_rd_data == TILE_BITS'(match_tile_reg));
                end
                if (nb_cnt_reg == NB_CNT_W'(NB_COUNT)) begin
                    rule_ptr_next = '0;
                    state_next    = ST_RULES;
                end else begin
                    nb_cnt_next = nb_cnt_reg + NB_CNT_W'(1);
                end
            end
            ST_RULES: begin
                if ((rule_ptr_reg != '0) && rule_ok) begin
                    res_tex_next = M_TDATA_W'(rule_rd_data[COND_W +: TEXTURE_BITS]);
                    res_fb_next  = 1'b0;
                    state_next   = ST_DONE;
                end else if (rule_ptr_reg == rules_eff) begin
                    res_tex_next = M_TDATA_W'(TEXTURE_BITS'(fallback_reg));
                    res_fb_next  = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    rule_ptr_next = rule_ptr_reg + RCNT_W'(1);
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            nb_cnt_reg   <= '0;
            rule_ptr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nb_cnt_reg   <= nb_cnt_next;
            rule_ptr_reg <= rule_ptr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            qx_reg <= in_x;
            qy_reg <= in_y;
        end
        onmap_q_reg <= ag_on_map;
        eq_reg      <= eq_next;
        res_tex_reg <= res_tex_next;
        res_fb_reg  <= res_fb_next;
        if (load_out) begin
            m_tdata_reg <= res_tex_reg;
            m_tuser_reg <= res_fb_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The neighbour counter never runs past the last neighbour's data.
    a_nb_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nb_cnt_reg <= NB_CNT_W'(NB_COUNT))
        else $error("neighbour counter out of range");

    // The rule pointer never passes the number of rules in use.
    a_rule_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RULES) |-> (rule_ptr_reg <= rules_eff))
        else $error("rule pointer beyond rule count");

    // A map write happens only while no query is reading the map.
    a_tile_we_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        tile_we |-> (state_reg == ST_IDLE))
        else $error("map write during a query");

    // A finished query always reaches the output register.
    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_tvalid && (state_reg == ST_IDLE)))
        else $error("finished query not presented");

endmodule

`default_nettype wire

[rtl/nrtm_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module nrtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/nrtm_nb_addr.sv]
// Neighbour coordinate, map bounds check and linear map address.
`default_nettype none

module nrtm_nb_addr
    import nrtm_pkg::*;
#(
    parameter int MAP_SIDE = MAP_SIDE_DEF
) (
    input  wire logic [COORD_W-1:0]                       x,
    input  wire logic [COORD_W-1:0]                       y,
    input  wire ofs_t                                     dx,
    input  wire ofs_t                                     dy,
    input  wire logic [$clog2(MAP_SIDE+1)-1:0]            width_eff,
    input  wire logic [$clog2(MAP_SIDE+1)-1:0]            height_eff,
    output logic                                          on_map,
    output logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]          addr
);

    localparam int DIM_W  = $clog2(MAP_SIDE + 1);
    localparam int ADDR_W = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int NC_W   = COORD_W + 1;
    localparam int CMP_W  = (DIM_W > NC_W) ? DIM_W : NC_W;
    localparam int SUM_W  = (ADDR_W > DIM_W + NC_W + 1) ? ADDR_W : DIM_W + NC_W + 1;

    logic            nx_neg;
    logic            ny_neg;
    logic [NC_W-1:0] nx;
    logic [NC_W-1:0] ny;
    logic [SUM_W-1:0] lin;

    always_comb begin
        nx_neg = (dx == OFS_NEG) && (x == '0);
        ny_neg = (dy == OFS_NEG) && (y == '0);
        case (dx)
            OFS_NEG: nx = NC_W'(x) - NC_W'(1);
            OFS_POS: nx = NC_W'(x) + NC_W'(1);
            default: nx = NC_W'(x);
        endcase
        case (dy)
            OFS_NEG: ny = NC_W'(y) - NC_W'(1);
            OFS_POS: ny = NC_W'(y) + NC_W'(1);
            default: ny = NC_W'(y);
        endcase
        on_map = !nx_neg && !ny_neg
                 && (CMP_W'(nx) < CMP_W'(width_eff))
                 && (CMP_W'(ny) < CMP_W'(height_eff));
        // Row-major: the effective width is the row pitch.
        lin  = SUM_W'(width_eff) * SUM_W'(ny) + SUM_W'(nx);
        addr = lin[ADDR_W-1:0];
    end

endmodule

`default_nettype wire
